>>> hdl/dpproj_pkg.sv
// dpproj_pkg: sizes, codes, beat types and helpers of the dark pixel projection block
// shared by every file in hdl but dpproj_ram; depends on nothing
`timescale 1ns / 1ps

package dpproj_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// positions and store addressing follow the frame limits
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// fixed field widths
	localparam int DIM_W     = 11;
	localparam int PIX_W     = 8;
	localparam int SEL_W     = 10;
	localparam int LINE_W    = 10;
	localparam int CNT_W     = 11;
	localparam int CFG_IDX_W = 1;

	// wide enough for positions, limits up to 4096 and the 11-bit registers, plus one
	localparam int EXT_W = 14;

	localparam logic [CNT_W-1:0] CNT_MAX      = '1;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	localparam logic KIND_ROW = 1'b0;
	localparam logic KIND_COL = 1'b1;

	typedef struct packed {
		logic             func;
		logic [PIX_W-1:0] pixel_value;
		logic [SEL_W-1:0] column_select;
	} in_beat_t;

	typedef struct packed {
		logic              result_kind;
		logic [LINE_W-1:0] line_index;
		logic [CNT_W-1:0]  zero_count;
		logic              frame_done;
	} out_beat_t;

	// one accepted item on its way to the read-modify-write stage
	typedef struct packed {
		logic              is_read;
		logic [COL_W-1:0]  addr;
		logic              sel_ok;
		logic              row_first;
		logic              hit;
		logic              row_end;
		logic              last_row;
		logic [LINE_W-1:0] line;
		logic [CNT_W-1:0]  row_count;
	} op_t;

	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] addr;
		logic [CNT_W-1:0] data;
	} ram_wr_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic hit);
		return (c == CNT_MAX) ? c : c + CNT_W'(hit);
	endfunction

endpackage

>>> hdl/dpproj_if.sv
// dpproj_in_if and dpproj_out_if: valid/ready channels carrying input and result beats
// depends on dpproj_pkg
`timescale 1ns / 1ps

interface dpproj_in_if import dpproj_pkg::*; ();
	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dpproj_out_if import dpproj_pkg::*; ();
	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/dpproj_ram.sv
// dpproj_ram: generic simple dual-port ram, one write and one registered read per cycle
// read returns the old word on a same-cycle write; no dependencies
`timescale 1ns / 1ps

module dpproj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/dpproj_seq.sv
// dpproj_seq: size registers, raster position tracking and running row count
// builds one op per beat for the read-modify-write stage; depends on dpproj_pkg
`timescale 1ns / 1ps

module dpproj_seq import dpproj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  in_beat_t             in_data,
	input  logic                 accept,
	output op_t                  op
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] row_cnt_q;

	logic [EXT_W-1:0] w_eff;
	logic [EXT_W-1:0] h_eff;
	logic             is_read;
	logic             hit;
	logic             row_end;
	logic             last_row;
	logic [CNT_W-1:0] row_cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		// zero means one, above the limit saturates
		if (width_q == '0) begin
			w_eff = EXT_W'(1);
		end else if (EXT_W'(width_q) > EXT_W'(MAX_WIDTH)) begin
			w_eff = EXT_W'(MAX_WIDTH);
		end else begin
			w_eff = EXT_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = EXT_W'(1);
		end else if (EXT_W'(height_q) > EXT_W'(MAX_HEIGHT)) begin
			h_eff = EXT_W'(MAX_HEIGHT);
		end else begin
			h_eff = EXT_W'(height_q);
		end

		is_read     = (in_data.func == FUNC_READ);
		hit         = (in_data.pixel_value == '0);
		row_end     = (EXT_W'(col_q) + EXT_W'(1)) >= w_eff;
		last_row    = (EXT_W'(row_q) + EXT_W'(1)) >= h_eff;
		row_cnt_nxt = sat_inc(row_cnt_q, hit);

		op.is_read   = is_read;
		op.addr      = is_read ? COL_W'(in_data.column_select) : col_q;
		op.sel_ok    = EXT_W'(in_data.column_select) < EXT_W'(MAX_WIDTH);
		op.row_first = (row_q == '0);
		op.hit       = hit;
		op.row_end   = row_end;
		op.last_row  = last_row;
		op.line      = is_read ? LINE_W'(in_data.column_select) : LINE_W'(row_q);
		op.row_count = row_cnt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_cnt_q <= '0;
		end else if (accept && !is_read) begin
			if (row_end) begin
				col_q     <= '0;
				row_q     <= last_row ? '0 : row_q + ROW_W'(1);
				row_cnt_q <= '0;
			end else begin
				col_q     <= col_q + COL_W'(1);
				row_cnt_q <= row_cnt_nxt;
			end
		end
	end

endmodule

>>> hdl/dpproj_rmw.sv
// dpproj_rmw: column store update stage with write forwarding, and the result register
// takes ops from dpproj_seq and read data from dpproj_ram; depends on dpproj_pkg
`timescale 1ns / 1ps

module dpproj_rmw import dpproj_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  op_t              op,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CNT_W-1:0] ram_rdata,
	output ram_wr_t          ram_wr,
	output logic             out_valid,
	input  logic             out_ready,
	output out_beat_t        out_data
);

	logic             valid_s1;
	op_t              op_s1;
	logic             fwd_valid_q;
	logic [COL_W-1:0] fwd_addr_q;
	logic [CNT_W-1:0] fwd_data_q;
	logic             out_valid_q;
	out_beat_t        out_data_q;

	logic             has_result;
	logic             out_free;
	logic             fire_s1;
	logic [CNT_W-1:0] cur;
	logic [CNT_W-1:0] upd;
	out_beat_t        res;

	always_comb begin
		// the last write is the newest value of its entry, whatever came between
		cur = (fwd_valid_q && fwd_addr_q == op_s1.addr) ? fwd_data_q : ram_rdata;
		// first row of a frame overwrites, so the store needs no clear
		upd = op_s1.row_first ? CNT_W'(op_s1.hit) : sat_inc(cur, op_s1.hit);

		has_result = op_s1.is_read || op_s1.row_end;
		out_free   = !out_valid_q || out_ready;
		fire_s1    = valid_s1 && (!has_result || out_free);
		in_ready   = !valid_s1 || fire_s1;

		ram_wr.we   = fire_s1 && !op_s1.is_read;
		ram_wr.addr = op_s1.addr;
		ram_wr.data = upd;

		if (op_s1.is_read) begin
			res.result_kind = KIND_COL;
			res.line_index  = op_s1.line;
			res.zero_count  = op_s1.sel_ok ? cur : '0;
			res.frame_done  = 1'b0;
		end else begin
			res.result_kind = KIND_ROW;
			res.line_index  = op_s1.line;
			res.zero_count  = op_s1.row_count;
			res.frame_done  = op_s1.last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ram_wr.we) begin
				fwd_valid_q <= 1'b1;
			end
			if (fire_s1 && has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op;
		end
		if (ram_wr.we) begin
			fwd_addr_q <= ram_wr.addr;
			fwd_data_q <= ram_wr.data;
		end
		if (fire_s1 && has_result) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> hdl/dark_pixel_row_column_projection.sv
// Dark pixel row and column projection: counts zero pixels per row and per column of a
// raster frame. The block takes one beat per clock, pixel or column read, and a beat that
// has a result shows it on the result channel once it has passed the update stage and then
// the result register; the pace is set by the single
// read-modify-write of the column store per pixel, one store read and one store write in
// each cycle, with the last write forwarded when the next beat hits the same column. The
// input stalls only while a result waits in the result register and the update stage holds
// another beat that has a result. The column store needs no clearing pass: row 0 of each
// frame writes every column fresh, and a column read before any row 0 has written that entry
// returns an undefined count.
// depends on dpproj_pkg, dpproj_if, dpproj_ram, dpproj_seq and dpproj_rmw
`timescale 1ns / 1ps

module dark_pixel_row_column_projection import dpproj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	dpproj_in_if.sink            pixels,
	dpproj_out_if.source         results
);

	op_t              op;
	ram_wr_t          ram_wr;
	logic [CNT_W-1:0] ram_rdata;
	logic             accept;

	assign accept = pixels.valid && pixels.ready;

	dpproj_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (pixels.data),
		.accept    (accept),
		.op        (op)
	);

	dpproj_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (accept),
		.raddr (op.addr),
		.rdata (ram_rdata)
	);

	dpproj_rmw u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_valid  (pixels.valid),
		.in_ready  (pixels.ready),
		.ram_rdata (ram_rdata),
		.ram_wr    (ram_wr),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (results.data)
	);

`ifndef SYNTHESIS
	// a row never holds more pixels than the widest frame
	a_row_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.result_kind == KIND_ROW
		|-> results.data.zero_count <= CNT_W'(MAX_WIDTH))
		else $error("row count above frame width");

	a_col_no_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.result_kind == KIND_COL
		|-> !results.data.frame_done)
		else $error("frame_done on a column result");

	// a store write comes only from a pixel accepted the cycle before or held since
	a_write_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.we |-> $past(accept) || $past(!pixels.ready))
		else $error("store write without a pending pixel");
`endif

endmodule

>>> dv/dark_pixel_projection_checker.sv
// dark_pixel_projection_checker: watches the pixel and result channels and the register port,
// predicts every row and column count and compares each result beat with the oldest prediction
// depends on dpproj_pkg and dpproj_if
`timescale 1ns / 1ps

module dark_pixel_projection_checker import dpproj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	dpproj_in_if                 pixels,
	dpproj_out_if                results,
	output int                   mismatches,
	output int                   outstanding,
	output int                   rows_checked,
	output int                   frames_checked,
	output int                   reads_checked
);

	localparam int SHOW_LIMIT = 10;

	logic [DIM_W-1:0]  width_reg;
	logic [DIM_W-1:0]  height_reg;
	logic [COL_W-1:0]  col_pos;
	logic [ROW_W-1:0]  row_pos;
	logic [CNT_W-1:0]  row_zeros;
	logic [CNT_W-1:0]  col_zeros [MAX_WIDTH];
	out_beat_t         pending_counts [$];

	function automatic int dim_limit(input logic [DIM_W-1:0] raw, input int ceiling);
		if (raw == '0)
			return 1;
		if (int'(raw) > ceiling)
			return ceiling;
		return int'(raw);
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic hit);
		if (c == '1)
			return c;
		return c + CNT_W'(hit);
	endfunction

	// returns 1 when the beat produces a result, which is then in got
	function automatic bit project_beat(input in_beat_t b, output out_beat_t got);
		int   w;
		int   h;
		logic hit;
		w = dim_limit(width_reg, MAX_WIDTH);
		h = dim_limit(height_reg, MAX_HEIGHT);
		got = '0;
		if (b.func == FUNC_READ) begin
			got.result_kind = KIND_COL;
			got.line_index  = LINE_W'(b.column_select);
			got.zero_count  = (int'(b.column_select) < MAX_WIDTH) ? col_zeros[b.column_select] : '0;
			got.frame_done  = 1'b0;
			return 1'b1;
		end
		hit = (b.pixel_value == '0);
		// row 0 overwrites the column total, later rows add to it
		if (row_pos == '0)
			col_zeros[col_pos] = CNT_W'(hit);
		else
			col_zeros[col_pos] = bump(col_zeros[col_pos], hit);
		row_zeros = bump(row_zeros, hit);
		if (int'(col_pos) + 1 >= w) begin
			got.result_kind = KIND_ROW;
			got.line_index  = LINE_W'(row_pos);
			got.zero_count  = row_zeros;
			got.frame_done  = (int'(row_pos) + 1 >= h);
			row_zeros = '0;
			col_pos   = '0;
			row_pos   = got.frame_done ? '0 : row_pos + 1'b1;
			return 1'b1;
		end
		col_pos = col_pos + 1'b1;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		out_beat_t got;
		if (!arst_n) begin
			width_reg   = WIDTH_RESET;
			height_reg  = HEIGHT_RESET;
			col_pos     = '0;
			row_pos     = '0;
			row_zeros   = '0;
			pending_counts.delete();
			mismatches     = 0;
			rows_checked   = 0;
			frames_checked = 0;
			reads_checked  = 0;
			outstanding   <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == CFG_HEIGHT)
					height_reg = cfg_data;
			end
			if (pixels.valid && pixels.ready) begin
				if (project_beat(pixels.data, want))
					pending_counts.push_back(want);
			end
			if (results.valid && results.ready) begin
				got = results.data;
				if (pending_counts.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("unexpected result at %0t: kind %0d line %0d count %0d done %0d",
							$time, got.result_kind, got.line_index, got.zero_count,
							got.frame_done);
				end else begin
					want = pending_counts.pop_front();
					if (got.result_kind != want.result_kind || got.line_index != want.line_index
						|| got.zero_count != want.zero_count
						|| got.frame_done != want.frame_done) begin
						mismatches++;
						if (mismatches <= SHOW_LIMIT) begin
							$write("mismatch at %0t: want kind %0d line %0d count %0d done %0d,",
								$time, want.result_kind, want.line_index, want.zero_count,
								want.frame_done);
							$display(" got kind %0d line %0d count %0d done %0d",
								got.result_kind, got.line_index, got.zero_count,
								got.frame_done);
						end
					end
					if (want.result_kind == KIND_ROW) begin
						rows_checked++;
						if (want.frame_done)
							frames_checked++;
					end else begin
						reads_checked++;
					end
				end
			end
			outstanding <= pending_counts.size();
		end
	end

endmodule

>>> dv/dark_pixel_row_column_projection_test.sv
// dark_pixel_row_column_projection_test: clock, reset, register writes and beat traffic for
// the projection block, with a checker beside it; depends on dpproj_pkg, dpproj_if, the block
// and dark_pixel_projection_checker
`timescale 1ns / 1ps

module dark_pixel_row_column_projection_test import dpproj_pkg::*; ();

	localparam int WIDE_ITEMS   = 250;
	localparam int REST_ITEMS   = 620;
	localparam int STALL_CYCLES = 400;
	localparam int READ_PCT     = 15;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	int mismatches;
	int outstanding;
	int rows_checked;
	int frames_checked;
	int reads_checked;

	int send_idle_pct;
	int recv_idle_pct;
	bit stall_req;
	int stall_left;

	// stimulus-side position tracking, only to keep reads on columns some row 0 has written
	logic [DIM_W-1:0] width_raw;
	logic [DIM_W-1:0] height_raw;
	int               trk_col;
	int               trk_row;
	bit               col_written [MAX_WIDTH];
	logic [SEL_W-1:0] written_cols [$];

	int pixels_sent;
	int reads_sent;
	int reg_writes;
	int rest_sent;

	dpproj_in_if  pixels();
	dpproj_out_if results();

	dark_pixel_row_column_projection uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pixels),
		.results   (results)
	);

	dark_pixel_projection_checker count_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixels         (pixels),
		.results        (results),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.rows_checked   (rows_checked),
		.frames_checked (frames_checked),
		.reads_checked  (reads_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("timeout: %0d results still outstanding", outstanding);
		$display("Regression FAIL");
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		results.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req  = 1'b0;
				stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				results.ready <= 1'b0;
			end else begin
				results.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic int dim_limit(input logic [DIM_W-1:0] raw, input int ceiling);
		if (raw == '0)
			return 1;
		if (int'(raw) > ceiling)
			return ceiling;
		return int'(raw);
	endfunction

	function automatic void track_pixel();
		if (trk_row == 0 && !col_written[trk_col]) begin
			col_written[trk_col] = 1'b1;
			written_cols.push_back(SEL_W'(trk_col));
		end
		if (trk_col + 1 >= dim_limit(width_raw, MAX_WIDTH)) begin
			trk_col = 0;
			trk_row = (trk_row + 1 >= dim_limit(height_raw, MAX_HEIGHT)) ? 0 : trk_row + 1;
		end else begin
			trk_col++;
		end
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 10)
			return '1;
		if (roll < 14)
			return DIM_W'(1024);
		if (roll < 45)
			return DIM_W'($urandom_range(1, 3));
		return DIM_W'($urandom_range(4, 24));
	endfunction

	task automatic send_beat(input logic func, input logic [PIX_W-1:0] pix,
		input logic [SEL_W-1:0] sel);
		in_beat_t beat;
		beat.func          = func;
		beat.pixel_value   = pix;
		beat.column_select = sel;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			pixels.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.data  <= beat;
		@(posedge clk);
		while (!pixels.ready)
			@(posedge clk);
		if (func == FUNC_PIXEL) begin
			track_pixel();
			pixels_sent++;
		end else begin
			reads_sent++;
		end
	endtask

	task automatic send_random_beat();
		if (written_cols.size() > 0 && $urandom_range(99) < READ_PCT)
			send_beat(FUNC_READ, PIX_W'($urandom),
				written_cols[$urandom_range(written_cols.size() - 1)]);
		else
			send_beat(FUNC_PIXEL, ($urandom_range(2) == 0) ? '0 : PIX_W'($urandom),
				SEL_W'($urandom));
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic settle();
		pixels.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WIDTH)
			width_raw = val;
		else
			height_raw = val;
		reg_writes++;
	endtask

	initial begin
		logic [DIM_W-1:0] w_pick;
		logic [DIM_W-1:0] h_pick;
		bit               stalled;
		bit               long_stall;
		int               n;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_WIDTH;
		cfg_data     = '0;
		pixels.valid = 1'b0;
		pixels.data  = '0;
		stall_req    = 1'b0;
		stalled      = 1'b0;
		width_raw    = WIDTH_RESET;
		height_raw   = HEIGHT_RESET;
		trk_col      = 0;
		trk_row      = 0;
		pixels_sent  = 0;
		reads_sent   = 0;
		reg_writes   = 0;
		rest_sent    = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (col_written[i])
			col_written[i] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x2 frame: mixed zeros, reads in and between rows
		write_reg(CFG_WIDTH, DIM_W'(3));
		write_reg(CFG_HEIGHT, DIM_W'(2));
		send_beat(FUNC_PIXEL, 8'd0, '0);
		send_beat(FUNC_PIXEL, 8'd255, '1);
		send_beat(FUNC_PIXEL, 8'd0, '0);
		send_beat(FUNC_READ, 8'd0, SEL_W'(0));
		send_beat(FUNC_READ, 8'd255, SEL_W'(2));
		send_beat(FUNC_PIXEL, 8'd0, '0);
		send_beat(FUNC_READ, 8'd0, SEL_W'(0));
		send_beat(FUNC_PIXEL, 8'd1, '0);
		send_beat(FUNC_PIXEL, 8'd0, '0);
		send_beat(FUNC_READ, 8'd0, SEL_W'(1));

		// zero width and height behave as one
		write_reg(CFG_WIDTH, '0);
		write_reg(CFG_HEIGHT, '0);
		send_beat(FUNC_PIXEL, 8'd0, '0);
		send_beat(FUNC_PIXEL, 8'd128, '0);
		send_beat(FUNC_READ, 8'd0, SEL_W'(0));

		// shrink width, then height, with the row already past the new limits
		write_reg(CFG_WIDTH, DIM_W'(5));
		write_reg(CFG_HEIGHT, DIM_W'(3));
		send_beat(FUNC_PIXEL, 8'd0, '0);
		send_beat(FUNC_PIXEL, 8'd0, '0);
		send_beat(FUNC_PIXEL, 8'd0, '0);
		write_reg(CFG_WIDTH, DIM_W'(2));
		send_beat(FUNC_PIXEL, 8'd0, '0);
		write_reg(CFG_HEIGHT, DIM_W'(1));
		send_beat(FUNC_PIXEL, 8'd7, '0);
		send_beat(FUNC_PIXEL, 8'd0, '0);
		send_beat(FUNC_READ, 8'd0, SEL_W'(3));

		// a long stretch of row 0 at saturated width spreads written columns over the store
		send_idle_pct = 13;
		recv_idle_pct = 79;
		write_reg(CFG_WIDTH, '1);
		write_reg(CFG_HEIGHT, '0);
		repeat (WIDE_ITEMS)
			send_random_beat();

		while (rest_sent < REST_ITEMS) begin
			if (rest_sent < REST_ITEMS / 3) begin
				send_idle_pct = 13;
				recv_idle_pct = 79;
			end else if (rest_sent < 2 * REST_ITEMS / 3) begin
				send_idle_pct = 79;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			w_pick = pick_dim();
			h_pick = pick_dim();
			// width 1 makes every pixel a row end, so the hold-off backs up the block fast
			long_stall = !stalled && rest_sent >= 2 * REST_ITEMS / 3;
			if (long_stall)
				w_pick = DIM_W'(1);
			if ($urandom_range(1) == 0) begin
				write_reg(CFG_WIDTH, w_pick);
				write_reg(CFG_HEIGHT, h_pick);
			end else begin
				write_reg(CFG_HEIGHT, h_pick);
				write_reg(CFG_WIDTH, w_pick);
			end
			if (long_stall) begin
				stall_req = 1'b1;
				stalled   = 1'b1;
			end
			n = $urandom_range(20, 80);
			repeat (n) begin
				send_random_beat();
				rest_sent++;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("sent %0d pixel beats and %0d column reads over %0d register writes",
			pixels_sent, reads_sent, reg_writes);
		$display("compared %0d row counts (%0d closing a frame) and %0d column counts",
			rows_checked, frames_checked, reads_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
